/* src/ehr_pkg.sv */
// Shared constants and types for the edit history ring.
`default_nettype none
package ehr_pkg;
   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int ENTRY_CHARS_DEF   = 32;
   localparam int POSITION_BITS_DEF = 20;
   localparam int MODE_BITS         = 2;
   localparam int CHAR_BITS         = 8;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_UNDO   = 2'd2,
      MODE_REDO   = 2'd3
   } mode_type;

   localparam logic KIND_INS = 1'b0;
   localparam logic KIND_DEL = 1'b1;
endpackage
`default_nettype wire

/* src/ehr_if.sv */
// Valid/ready channel interfaces for event requests and edit responses.
`default_nettype none
interface ehr_req_if #(parameter int POS_BITS = ehr_pkg::POSITION_BITS_DEF);
   import ehr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [CHAR_BITS-1:0] char_in;
   logic [POS_BITS-1:0]  text_pos;
   modport source (output valid, mode, char_in, text_pos, input ready);
   modport sink (input valid, mode, char_in, text_pos, output ready);
endinterface

interface ehr_rsp_if #(
   parameter int POS_BITS = ehr_pkg::POSITION_BITS_DEF,
   parameter int LEN_BITS = 6
);
   import ehr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 edit_kind;
   logic [POS_BITS-1:0]  edit_pos;
   logic [CHAR_BITS-1:0] char_out;
   logic [LEN_BITS-1:0]  span_len;
   logic                 last_of_run;
   modport source (output valid, edit_kind, edit_pos, char_out, span_len, last_of_run,
                   input ready);
   modport sink (input valid, edit_kind, edit_pos, char_out, span_len, last_of_run,
                 output ready);
endinterface
`default_nettype wire

/* src/ehr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ehr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* src/edit_history_ring_with_merge_core.sv */
// Top level: undo/redo history ring with per-character merging of typing.
`default_nettype none
// Each request records an inserted or deleted character, or asks for an undo or a redo.
// Entries live in a ring of HISTORY_DEPTH slots, of which at most HISTORY_DEPTH - 1 hold
// undoable history; characters sit in a RAM of ENTRY_CHARS bytes per slot. One sequencer
// works one request at a time through the two RAM read ports (registered read data), and
// req_ch.ready is high only while it is idle. A record reads the newest entry's metadata,
// then writes; a backspace that merges into an entry reads every stored byte and writes
// it back one place up through the single character port; an undo or redo with nothing
// to do leaves the sequencer idle; a delete response waits out any output stall; a
// reinsert emits one response per character, each after its byte read and any stall.
// No clearing pass follows reset: entries outside the held range are never read.
module edit_history_ring_with_merge_core #(
   parameter int HISTORY_DEPTH = ehr_pkg::HISTORY_DEPTH_DEF,
   parameter int ENTRY_CHARS   = ehr_pkg::ENTRY_CHARS_DEF,
   parameter int POSITION_BITS = ehr_pkg::POSITION_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ehr_req_if.sink  req_ch,
   ehr_rsp_if.source rsp_ch
);
   import ehr_pkg::*;

   localparam int IW = $clog2(HISTORY_DEPTH);
   localparam int IB = (ENTRY_CHARS > 1) ? $clog2(ENTRY_CHARS) : 1;
   localparam int LB = $clog2(ENTRY_CHARS + 1);
   localparam int PB = POSITION_BITS;
   localparam int MW = 1 + PB + LB;
   localparam int CHAR_DEPTH = HISTORY_DEPTH * (2 ** IB);
   localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(HISTORY_DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
   localparam logic [LB-1:0] FULL_LEN = LB'(ENTRY_CHARS);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_META     = 8'b0000_0010,
      S_SHIFT_RD = 8'b0000_0100,
      S_SHIFT_WR = 8'b0000_1000,
      S_PREP_FIN = 8'b0001_0000,
      S_CHAR_RD  = 8'b0010_0000,
      S_CHAR_LD  = 8'b0100_0000,
      S_EMIT     = 8'b1000_0000
   } state_type;

   function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] a);
      return (a == LAST_IDX) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] a);
      return (a == '0) ? LAST_IDX : a - 1'b1;
   endfunction

   function automatic logic [IW-1:0] sub_idx(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW:0] t;
      t = {1'b0, a} + DEPTH_W - {1'b0, b};
      if (t >= DEPTH_W) begin
         t = t - DEPTH_W;
      end
      return t[IW-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [IW-1:0]        head_ff, head_in, cursor_ff, cursor_in, held_ff, held_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic [IB-1:0]        idx_ff, idx_in;
   mode_type             mode_ff, mode_in;
   logic [CHAR_BITS-1:0] ch_ff, ch_in;
   logic [PB-1:0]        pos_ff, pos_in;
   logic                 e_kind_ff, e_kind_in;
   logic [PB-1:0]        e_pos_ff, e_pos_in;
   logic [LB-1:0]        e_len_ff, e_len_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_kind_ff, out_kind_in;
   logic [PB-1:0]        out_pos_ff, out_pos_in;
   logic [CHAR_BITS-1:0] out_char_ff, out_char_in;
   logic [LB-1:0]        out_span_ff, out_span_in;
   logic                 out_last_ff, out_last_in;

   logic                 meta_we;
   logic [IW-1:0]        meta_waddr, meta_raddr;
   logic [MW-1:0]        meta_wdata, meta_rdata;
   logic                 char_we;
   logic [IW+IB-1:0]     char_waddr, char_raddr;
   logic [CHAR_BITS-1:0] char_wdata, char_rdata;

   logic                 m_kind;
   logic [PB-1:0]        m_pos;
   logic [LB-1:0]        m_len;
   logic [IW-1:0]        bottom, base, slot_sel;
   logic                 at_head, undo_ok, redo_ok, mergeable;
   logic                 ins_hit, fwd_hit, back_hit, as_insert;
   logic                 req_fire, rsp_fire;

   ehr_ram #(.WIDTH(MW), .DEPTH(HISTORY_DEPTH)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   ehr_ram #(.WIDTH(CHAR_BITS), .DEPTH(CHAR_DEPTH)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (char_waddr),
      .wr_data (char_wdata),
      .rd_addr (char_raddr),
      .rd_data (char_rdata)
   );

   assign m_kind = meta_rdata[MW-1];
   assign m_pos  = meta_rdata[LB +: PB];
   assign m_len  = meta_rdata[LB-1:0];

   assign bottom    = sub_idx(head_ff, held_ff);
   assign at_head   = (cursor_ff == head_ff);
   assign undo_ok   = (held_ff != '0) && (cursor_ff != bottom);
   assign redo_ok   = !at_head;
   assign base      = at_head ? held_ff : sub_idx(cursor_ff, bottom);
   assign mergeable = (held_ff != '0) && at_head && (m_len < FULL_LEN);
   assign ins_hit   = ({1'b0, m_pos} + (PB + 1)'(m_len)) == {1'b0, pos_ff};
   assign fwd_hit   = (m_pos == pos_ff);
   assign back_hit  = ({1'b0, pos_ff} + 1'b1) == {1'b0, m_pos};
   assign as_insert = (mode_ff == MODE_UNDO) ? (m_kind == KIND_DEL) : (m_kind == KIND_INS);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;

   always_comb begin
      case (mode_type'(req_ch.mode))
         MODE_UNDO: slot_sel = dec_idx(cursor_ff);
         MODE_REDO: slot_sel = cursor_ff;
         default:   slot_sel = dec_idx(head_ff);
      endcase
   end

   assign meta_raddr = (state_ff == S_IDLE) ? slot_sel : slot_ff;
   assign char_raddr = {slot_ff, idx_ff};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cursor_in    = cursor_ff;
      held_in      = held_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      ch_in        = ch_ff;
      pos_in       = pos_ff;
      e_kind_in    = e_kind_ff;
      e_pos_in     = e_pos_ff;
      e_len_in     = e_len_ff;
      rsp_valid_in = rsp_valid_ff;
      out_kind_in  = out_kind_ff;
      out_pos_in   = out_pos_ff;
      out_char_in  = out_char_ff;
      out_span_in  = out_span_ff;
      out_last_in  = out_last_ff;
      meta_we      = 1'b0;
      meta_waddr   = slot_ff;
      meta_wdata   = {e_kind_ff, e_pos_ff, e_len_ff};
      char_we      = 1'b0;
      char_waddr   = {slot_ff, idx_ff};
      char_wdata   = ch_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in = mode_type'(req_ch.mode);
               ch_in   = req_ch.char_in;
               pos_in  = req_ch.text_pos;
               slot_in = slot_sel;
               case (mode_type'(req_ch.mode))
                  MODE_UNDO: begin
                     if (undo_ok) begin
                        cursor_in = dec_idx(cursor_ff);
                        state_in  = S_META;
                     end
                  end
                  MODE_REDO: begin
                     if (redo_ok) begin
                        cursor_in = inc_idx(cursor_ff);
                        state_in  = S_META;
                     end
                  end
                  default: state_in = S_META;
               endcase
            end
         end
         S_META: begin
            e_kind_in = m_kind;
            e_pos_in  = m_pos;
            e_len_in  = m_len;
            idx_in    = '0;
            state_in  = S_IDLE;
            if (mode_ff inside {MODE_INSERT, MODE_DELETE}) begin
               if (mergeable && mode_ff == MODE_INSERT && m_kind == KIND_INS && ins_hit) begin
                  // Append to the newest insert entry.
                  char_we    = 1'b1;
                  char_waddr = {slot_ff, m_len[IB-1:0]};
                  meta_we    = 1'b1;
                  meta_wdata = {m_kind, m_pos, m_len + 1'b1};
               end else if (mergeable && mode_ff == MODE_DELETE && m_kind == KIND_DEL &&
                            fwd_hit) begin
                  char_we    = 1'b1;
                  char_waddr = {slot_ff, m_len[IB-1:0]};
                  meta_we    = 1'b1;
                  meta_wdata = {m_kind, m_pos, m_len + 1'b1};
               end else if (mergeable && mode_ff == MODE_DELETE && m_kind == KIND_DEL &&
                            back_hit) begin
                  // Backspace: shift stored bytes up one, top first.
                  idx_in   = IB'(m_len - 1'b1);
                  state_in = S_SHIFT_RD;
               end else begin
                  // Open a new entry at the cursor; drop any redo history.
                  meta_we    = 1'b1;
                  meta_waddr = cursor_ff;
                  meta_wdata = {(mode_ff == MODE_DELETE) ? KIND_DEL : KIND_INS, pos_ff,
                                LB'(1)};
                  char_we    = 1'b1;
                  char_waddr = {cursor_ff, IB'(0)};
                  held_in    = (base < LAST_IDX) ? base + 1'b1 : base;
                  head_in    = inc_idx(cursor_ff);
                  cursor_in  = inc_idx(cursor_ff);
               end
            end else if (as_insert) begin
               state_in = S_CHAR_RD;
            end else begin
               rsp_valid_in = 1'b1;
               out_kind_in  = KIND_DEL;
               out_pos_in   = m_pos;
               out_char_in  = '0;
               out_span_in  = m_len;
               out_last_in  = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            char_we    = 1'b1;
            char_waddr = {slot_ff, idx_ff + 1'b1};
            char_wdata = char_rdata;
            if (idx_ff == '0) begin
               state_in = S_PREP_FIN;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_SHIFT_RD;
            end
         end
         S_PREP_FIN: begin
            char_we    = 1'b1;
            char_waddr = {slot_ff, IB'(0)};
            meta_we    = 1'b1;
            meta_wdata = {KIND_DEL, pos_ff, e_len_ff + 1'b1};
            state_in   = S_IDLE;
         end
         S_CHAR_RD: state_in = S_CHAR_LD;
         S_CHAR_LD: begin
            rsp_valid_in = 1'b1;
            out_kind_in  = KIND_INS;
            out_pos_in   = e_pos_ff + PB'(idx_ff);
            out_char_in  = char_rdata;
            out_span_in  = '0;
            out_last_in  = (LB'(idx_ff) + 1'b1) == e_len_ff;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_CHAR_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         cursor_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cursor_ff    <= cursor_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      mode_ff     <= mode_in;
      ch_ff       <= ch_in;
      pos_ff      <= pos_in;
      e_kind_ff   <= e_kind_in;
      e_pos_ff    <= e_pos_in;
      e_len_ff    <= e_len_in;
      out_kind_ff <= out_kind_in;
      out_pos_ff  <= out_pos_in;
      out_char_ff <= out_char_in;
      out_span_ff <= out_span_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.edit_kind   = out_kind_ff;
   assign rsp_ch.edit_pos    = out_pos_ff;
   assign rsp_ch.char_out    = out_char_ff;
   assign rsp_ch.span_len    = out_span_ff;
   assign rsp_ch.last_of_run = out_last_ff;
endmodule
`default_nettype wire

/* test/tb_edit_history_ring_with_merge_core.sv */
// Testbench for the edit history ring: directed and random events, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_edit_history_ring_with_merge_core;
   import ehr_pkg::*;

   localparam int DEPTH = HISTORY_DEPTH_DEF;
   localparam int NCHAR = ENTRY_CHARS_DEF;
   localparam int PBITS = POSITION_BITS_DEF;
   localparam logic [PBITS-1:0] POS_MAX = '1;

   typedef struct packed {
      logic             kind;
      logic [PBITS-1:0] pos;
      logic [7:0]       ch;
      logic [5:0]       span;
      logic             last;
   } edit_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ehr_req_if #(.POS_BITS(PBITS)) req_ch ();
   ehr_rsp_if #(.POS_BITS(PBITS), .LEN_BITS(6)) rsp_ch ();

   edit_history_ring_with_merge_core u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic             hist_kind [DEPTH];
   logic [PBITS-1:0] hist_pos  [DEPTH];
   int               hist_len  [DEPTH];
   logic [7:0]       hist_chars[DEPTH][NCHAR];
   int               head_q = 0;
   int               cursor_q = 0;
   int               held_q = 0;

   edit_t expected_edits[$];
   int    fail_count = 0;

   function automatic int oldest_slot();
      return (head_q + DEPTH - held_q) % DEPTH;
   endfunction

   function automatic void open_entry(logic kind, logic [7:0] ch, logic [PBITS-1:0] pos);
      int base;
      if (cursor_q != head_q) begin
         base = oldest_slot();
         head_q = cursor_q;
         held_q = (head_q + DEPTH - base) % DEPTH;
      end
      hist_kind[head_q] = kind;
      hist_pos[head_q] = pos;
      hist_chars[head_q][0] = ch;
      hist_len[head_q] = 1;
      if (held_q < DEPTH - 1) held_q++;
      head_q = (head_q + 1) % DEPTH;
      cursor_q = head_q;
   endfunction

   function automatic void play_entry(int s, bit as_insert);
      edit_t e;
      for (int i = 0; i < (as_insert ? hist_len[s] : 1); i++) begin
         e.kind = as_insert ? KIND_INS : KIND_DEL;
         e.pos  = hist_pos[s] + PBITS'(i);
         e.ch   = as_insert ? hist_chars[s][i] : 8'd0;
         e.span = as_insert ? 6'd0 : 6'(hist_len[s]);
         e.last = as_insert ? (i + 1 == hist_len[s]) : 1'b1;
         expected_edits.push_back(e);
      end
   endfunction

   function automatic void predict_edits(mode_type mode, logic [7:0] ch, logic [PBITS-1:0] pos);
      int  p;
      bit  merge_ok;
      p = (head_q + DEPTH - 1) % DEPTH;
      merge_ok = held_q != 0 && cursor_q == head_q && hist_len[p] < NCHAR;
      case (mode)
         MODE_INSERT: begin
            if (merge_ok && hist_kind[p] == KIND_INS &&
                  {1'b0, hist_pos[p]} + 21'(hist_len[p]) == {1'b0, pos}) begin
               hist_chars[p][hist_len[p]] = ch;
               hist_len[p]++;
            end else open_entry(KIND_INS, ch, pos);
         end
         MODE_DELETE: begin
            if (merge_ok && hist_kind[p] == KIND_DEL && hist_pos[p] == pos) begin
               hist_chars[p][hist_len[p]] = ch;
               hist_len[p]++;
            end else if (merge_ok && hist_kind[p] == KIND_DEL &&
                  {1'b0, pos} + 21'd1 == {1'b0, hist_pos[p]}) begin
               for (int i = hist_len[p]; i > 0; i--) hist_chars[p][i] = hist_chars[p][i-1];
               hist_chars[p][0] = ch;
               hist_pos[p] = pos;
               hist_len[p]++;
            end else open_entry(KIND_DEL, ch, pos);
         end
         MODE_UNDO: begin
            if (held_q != 0 && cursor_q != oldest_slot()) begin
               cursor_q = (cursor_q + DEPTH - 1) % DEPTH;
               play_entry(cursor_q, hist_kind[cursor_q] == KIND_DEL);
            end
         end
         default: begin
            if (cursor_q != head_q) begin
               play_entry(cursor_q, hist_kind[cursor_q] == KIND_INS);
               cursor_q = (cursor_q + 1) % DEPTH;
            end
         end
      endcase
   endfunction

   // valid stays high across a back-to-back transfer; drop it only before an idle gap
   task automatic send_event(mode_type mode, logic [7:0] ch, logic [PBITS-1:0] pos);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.char_in  <= ch;
      req_ch.text_pos <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_edits(mode, ch, pos);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_edits.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // check each response transfer
   always @(posedge clock) begin
      edit_t e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_edits.size() == 0) begin
            $error("unexpected edit: kind %0d pos %0d", rsp_ch.edit_kind, rsp_ch.edit_pos);
            fail_count++;
         end else begin
            e = expected_edits.pop_front();
            if (rsp_ch.edit_kind !== e.kind) begin
               $error("edit_kind exp %0d got %0d", e.kind, rsp_ch.edit_kind); fail_count++;
            end
            if (rsp_ch.edit_pos !== e.pos) begin
               $error("edit_pos exp %0d got %0d", e.pos, rsp_ch.edit_pos); fail_count++;
            end
            if (rsp_ch.char_out !== e.ch) begin
               $error("char_out exp %0d got %0d", e.ch, rsp_ch.char_out); fail_count++;
            end
            if (rsp_ch.span_len !== e.span) begin
               $error("span_len exp %0d got %0d", e.span, rsp_ch.span_len); fail_count++;
            end
            if (rsp_ch.last_of_run !== e.last) begin
               $error("last_of_run exp %0d got %0d", e.last, rsp_ch.last_of_run);
               fail_count++;
            end
         end
      end
   end

   // random response stalls, with stall-free stretches
   int stall_left = 0;
   int calm_left = 0;
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left <= $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
            if ($urandom_range(0, 15) == 0) calm_left <= 40;
         end
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else rsp_ch.ready <= 1'b1;
   end

   task automatic test_extremes();
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_REDO, 8'hFF, POS_MAX);
      send_event(MODE_INSERT, 8'hFF, POS_MAX);
      send_event(MODE_INSERT, 8'h00, '0);
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_REDO, 8'h00, '0);
      send_event(MODE_REDO, 8'h00, '0);
      send_event(MODE_REDO, 8'h00, '0);
      send_event(MODE_DELETE, 8'hA5, '0);
      send_event(MODE_DELETE, 8'h5A, POS_MAX);
      send_event(MODE_UNDO, 8'h00, '0);
      wait_drained();
   endtask

   task automatic test_merging();
      // backspace run, forward deletes, then typing past the entry limit
      for (int i = 0; i < 6; i++) send_event(MODE_DELETE, 8'(8'h40 + i), PBITS'(500 - i));
      for (int i = 0; i < 4; i++) send_event(MODE_DELETE, 8'(8'h60 + i), PBITS'(495));
      for (int i = 0; i < NCHAR + 3; i++) send_event(MODE_INSERT, 8'($urandom), PBITS'(1000 + i));
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_UNDO, 8'h00, '0);
      send_event(MODE_REDO, 8'h00, '0);
      // record with redo history pending discards it
      send_event(MODE_INSERT, 8'h21, PBITS'(1032));
      send_event(MODE_REDO, 8'h00, '0);
      wait_drained();
   endtask

   task automatic test_full_ring();
      for (int i = 0; i < DEPTH + 4; i++) send_event(MODE_INSERT, 8'(i), PBITS'(i * 7));
      for (int i = 0; i < DEPTH + 1; i++) send_event(MODE_UNDO, 8'h00, '0);
      for (int i = 0; i < 5; i++) send_event(MODE_REDO, 8'h00, '0);
      wait_drained();
   endtask

   task automatic test_random();
      logic [PBITS-1:0] pos;
      int r;
      pos = PBITS'($urandom);
      for (int n = 0; n < 50; n++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            send_event(MODE_INSERT, 8'($urandom), pos);
            pos = pos + 1'b1;
         end else if (r < 40) begin
            pos = pos - 1'b1;
            send_event(MODE_DELETE, 8'($urandom), pos);
         end else if (r < 47) send_event(MODE_DELETE, 8'($urandom), pos);
         else if (r < 67) send_event(MODE_UNDO, 8'($urandom), PBITS'($urandom));
         else if (r < 82) send_event(MODE_REDO, 8'($urandom), PBITS'($urandom));
         else begin
            pos = ($urandom_range(0, 7) == 0) ? POS_MAX - PBITS'($urandom_range(0, 3))
                                              : PBITS'($urandom);
            send_event(mode_type'($urandom_range(0, 1)), 8'($urandom), pos);
         end
         if (n == 25) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      req_ch.valid    <= 1'b0;
      req_ch.mode     <= MODE_INSERT;
      req_ch.char_in  <= '0;
      req_ch.text_pos <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_merging();
      test_full_ring();
      test_random();
      if (fail_count == 0 && expected_edits.size() == 0)
         $display("edit_history_ring_with_merge_core regression: pass");
      else
         $display("edit_history_ring_with_merge_core regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("edit_history_ring_with_merge_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
